>>> rtl/dnrb_pkg.sv
`default_nettype none

package dnrb_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int GAIN_BITS  = 12;
    localparam int NORM_SHIFT = 24;
    localparam int OUT_W      = 16;
    localparam int ROUGH_W    = 15;
    localparam int VEC_W      = 18;
    localparam int QUO_W      = 15;

    typedef enum logic
    {
        REG_INTENSITY   = 1'b0,
        REG_ROUGH_BLEND = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/dnrb_norm.sv
`default_nettype none

module dnrb_norm #(
    parameter int W  = 18,
    parameter int SW = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [W-1:0]                 in_x,
    input  logic signed [W-1:0]                 in_y,
    input  logic signed [W-1:0]                 in_z,
    input  logic [SW-1:0]                       in_side,
    output logic                                out_valid,
    output logic signed [dnrb_pkg::OUT_W-1:0]   out_x,
    output logic signed [dnrb_pkg::OUT_W-1:0]   out_y,
    output logic signed [dnrb_pkg::OUT_W-1:0]   out_z,
    output logic [SW-1:0]                       out_side
);

    localparam int SUM_W = 2 * W + 2;
    localparam int XW    = SUM_W + dnrb_pkg::NORM_SHIFT;
    localparam int RB    = XW / 2;
    localparam int RMW   = RB + 2;
    localparam int QB    = dnrb_pkg::QUO_W;
    localparam int OW    = dnrb_pkg::OUT_W;
    localparam int SH    = dnrb_pkg::FRAC_BITS + dnrb_pkg::GAIN_BITS;
    localparam int NW    = ((RB + QB > W + SH) ? RB + QB : W + SH) + 1;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][W-1:0]   mag;
        logic                zero;
        logic [SW-1:0]       side;
    } carry_t;

    // squares
    logic                   sq_valid_reg;
    carry_t                 sq_c_reg;
    logic [2:0][2*W-1:0]    sq_s_reg;
    logic [2:0][W-1:0]      in_mag;

    assign in_mag[0] = in_x[W-1] ? $unsigned(-in_x) : $unsigned(in_x);
    assign in_mag[1] = in_y[W-1] ? $unsigned(-in_y) : $unsigned(in_y);
    assign in_mag[2] = in_z[W-1] ? $unsigned(-in_z) : $unsigned(in_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_c_reg.neg  <= {in_z[W-1], in_y[W-1], in_x[W-1]};
            sq_c_reg.mag  <= in_mag;
            sq_c_reg.zero <= 1'b0;
            sq_c_reg.side <= in_side;
            sq_s_reg[0]   <= in_mag[0] * in_mag[0];
            sq_s_reg[1]   <= in_mag[1] * in_mag[1];
            sq_s_reg[2]   <= in_mag[2] * in_mag[2];
        end
    end

    // square root, two radicand bits per stage
    logic               rt_valid_reg [0:RB];
    logic [RB-1:0]      rt_root_reg  [0:RB];
    logic [RMW-1:0]     rt_rem_reg   [0:RB];
    logic [XW-1:0]      rt_x_reg     [0:RB];
    carry_t             rt_c_reg     [0:RB];
    logic [SUM_W-1:0]   len2;

    assign len2 = SUM_W'(sq_s_reg[0]) + SUM_W'(sq_s_reg[1]) + SUM_W'(sq_s_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            rt_valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_root_reg[0]    <= '0;
            rt_rem_reg[0]     <= '0;
            rt_x_reg[0]       <= {len2, {dnrb_pkg::NORM_SHIFT{1'b0}}};
            rt_c_reg[0].neg   <= sq_c_reg.neg;
            rt_c_reg[0].mag   <= sq_c_reg.mag;
            rt_c_reg[0].side  <= sq_c_reg.side;
            rt_c_reg[0].zero  <= (len2 == '0);
        end
    end

    for (genvar j = 0; j < RB; j++)
    begin : g_rt
        localparam int K = RB - 1 - j;
        logic [RMW+1:0] trial;
        logic [RMW+1:0] test;

        assign trial = {rt_rem_reg[j], rt_x_reg[j][2*K+1 -: 2]};
        assign test  = {2'b00, rt_root_reg[j], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                rt_valid_reg[j+1] <= rt_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_x_reg[j+1] <= rt_x_reg[j];
                rt_c_reg[j+1] <= rt_c_reg[j];
                if (trial >= test)
                begin
                    rt_rem_reg[j+1]  <= RMW'(trial - test);
                    rt_root_reg[j+1] <= {rt_root_reg[j][RB-2:0], 1'b1};
                end
                else
                begin
                    rt_rem_reg[j+1]  <= trial[RMW-1:0];
                    rt_root_reg[j+1] <= {rt_root_reg[j][RB-2:0], 1'b0};
                end
            end
        end
    end

    // rounded division by the length, one quotient bit per stage
    logic               dv_valid_reg [0:QB];
    logic [NW-1:0]      dv_rem_reg   [0:QB][0:2];
    logic [QB-1:0]      dv_q_reg     [0:QB][0:2];
    logic [RB-1:0]      dv_len_reg   [0:QB];
    carry_t             dv_c_reg     [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= rt_valid_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_len_reg[0] <= rt_root_reg[RB];
            dv_c_reg[0]   <= rt_c_reg[RB];
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= (NW'(rt_c_reg[RB].mag[c]) << SH)
                                    + NW'(rt_root_reg[RB] >> 1);
                dv_q_reg[0][c]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_dv
        localparam int K = QB - 1 - j;
        logic [NW-1:0] den;

        assign den = NW'(dv_len_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_c_reg[j+1]   <= dv_c_reg[j];
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (dv_rem_reg[j][c] >= den)
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem_reg[j][c] - den;
                        dv_q_reg[j+1][c]   <= dv_q_reg[j][c] | (QB'(1) << K);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][c] <= dv_rem_reg[j][c];
                        dv_q_reg[j+1][c]   <= dv_q_reg[j][c];
                    end
                end
            end
        end
    end

    // saturate, sign and zero-length fallback
    logic                       o_valid_reg;
    logic signed [OW-1:0]       o_reg  [0:2];
    logic signed [OW-1:0]       o_next [0:2];
    logic [SW-1:0]              o_side_reg;
    logic [QB-1:0]              qc;

    always_comb
    begin
        qc = '0;
        for (int c = 0; c < 3; c++)
        begin
            qc = (dv_q_reg[QB][c] > QB'(dnrb_pkg::ONE)) ? QB'(dnrb_pkg::ONE)
                                                        : dv_q_reg[QB][c];
            o_next[c] = dv_c_reg[QB].neg[c] ? -$signed(OW'(qc)) : $signed(OW'(qc));
        end
        if (dv_c_reg[QB].zero)
        begin
            o_next[0] = '0;
            o_next[1] = '0;
            o_next[2] = OW'(dnrb_pkg::ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0]   <= o_next[0];
            o_reg[1]   <= o_next[1];
            o_reg[2]   <= o_next[2];
            o_side_reg <= dv_c_reg[QB].side;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_x     = o_reg[0];
    assign out_y     = o_reg[1];
    assign out_z     = o_reg[2];
    assign out_side  = o_side_reg;

endmodule

`default_nettype wire

>>> rtl/detail_normal_roughness_blend.sv
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  macro_x/y/z, macro_rough, detail_x/y/z, detail_rough
// result    out        out_valid/out_ready  out_x, out_y, out_z, out_rough
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// one request per cycle while results are taken; a request passes stages a, b, the detail normaliser,
// stage c and the blended normaliser (each 50 stages: 31-step square root, 15-step divider)
// rst_n clears all valid bits and loads intensity 16384, rough_blend 0
// a held result freezes the whole pipeline; a request taken during that cycle
// waits in a one-entry skid register, so in_ready is a flop
`default_nettype none

module detail_normal_roughness_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  macro_x,
    input  logic signed [15:0]  macro_y,
    input  logic signed [15:0]  macro_z,
    input  logic [14:0]         macro_rough,
    input  logic signed [15:0]  detail_x,
    input  logic signed [15:0]  detail_y,
    input  logic signed [15:0]  detail_z,
    input  logic [14:0]         detail_rough,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  out_x,
    output logic signed [15:0]  out_y,
    output logic signed [15:0]  out_z,
    output logic [14:0]         out_rough,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int VW     = dnrb_pkg::VEC_W;
    localparam int RW     = dnrb_pkg::ROUGH_W;
    localparam int PROD_W = 34;
    localparam int RND_W  = 19;
    localparam int SIDE_W = 3 * 16 + RW;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic [14:0]        mr;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [14:0]        dr;
    } pix_t;

    function automatic logic signed [RND_W-1:0] round_frac(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
        q   = (mag + PROD_W'(dnrb_pkg::ONE / 2)) >> dnrb_pkg::FRAC_BITS;
        round_frac = p[PROD_W-1] ? -$signed(RND_W'(q)) : $signed(RND_W'(q));
    endfunction

    // configuration
    logic [15:0]    intensity_reg;
    logic [14:0]    rough_blend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg   <= 16'(dnrb_pkg::ONE);
            rough_blend_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dnrb_pkg::REG_INTENSITY:   intensity_reg   <= cfg_data;
                dnrb_pkg::REG_ROUGH_BLEND: rough_blend_reg <= cfg_data[14:0];
                default:                   intensity_reg   <= intensity_reg;
            endcase
        end
    end

    // skid and pipeline advance
    logic   en;
    logic   n2_valid;
    logic   skid_full_reg;
    pix_t   skid_reg;
    pix_t   req;
    pix_t   feed;
    logic   feed_valid;
    logic   in_fire;

    assign en        = !n2_valid || out_ready;
    assign in_ready  = !skid_full_reg;
    assign in_fire   = in_valid && in_ready;
    assign req       = '{mx: macro_x, my: macro_y, mz: macro_z, mr: macro_rough,
                         dx: detail_x, dy: detail_y, dz: detail_z, dr: detail_rough};
    assign feed       = skid_full_reg ? skid_reg : req;
    assign feed_valid = skid_full_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_fire)
        begin
            skid_reg <= req;
        end
    end

    // stage a: products
    logic                       fa_valid_reg;
    logic signed [PROD_W-1:0]   fa_px_reg;
    logic signed [PROD_W-1:0]   fa_py_reg;
    logic signed [PROD_W-1:0]   fa_pr_reg;
    pix_t                       fa_pix_reg;
    logic signed [VW-1:0]       rough_term;

    assign rough_term = $signed({2'b00, feed.dr, 1'b0}) - VW'(dnrb_pkg::ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fa_valid_reg <= feed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_px_reg  <= PROD_W'(feed.dx) * PROD_W'($signed({1'b0, intensity_reg}));
            fa_py_reg  <= PROD_W'(feed.dy) * PROD_W'($signed({1'b0, intensity_reg}));
            fa_pr_reg  <= PROD_W'(rough_term) * PROD_W'($signed({1'b0, rough_blend_reg}));
            fa_pix_reg <= feed;
        end
    end

    // stage b: rounding and roughness clamp
    logic                       fb_valid_reg;
    logic signed [VW-1:0]       fb_dx_reg;
    logic signed [VW-1:0]       fb_dy_reg;
    logic signed [VW-1:0]       fb_dz_reg;
    logic [SIDE_W-1:0]          fb_side_reg;
    logic signed [RND_W-1:0]    rough_sum;
    logic [RW-1:0]              rough_next;

    assign rough_sum = $signed(RND_W'(fa_pix_reg.mr)) + round_frac(fa_pr_reg);

    always_comb
    begin
        priority if (rough_sum < 0)
        begin
            rough_next = '0;
        end
        else if (rough_sum > RND_W'(dnrb_pkg::ONE))
        begin
            rough_next = RW'(dnrb_pkg::ONE);
        end
        else
        begin
            rough_next = rough_sum[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fb_valid_reg <= fa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fb_dx_reg   <= VW'(round_frac(fa_px_reg));
            fb_dy_reg   <= VW'(round_frac(fa_py_reg));
            fb_dz_reg   <= VW'(fa_pix_reg.dz);
            fb_side_reg <= {fa_pix_reg.mx, fa_pix_reg.my, fa_pix_reg.mz, rough_next};
        end
    end

    // detail normalise
    logic                   n1_valid;
    logic signed [15:0]     n1_x;
    logic signed [15:0]     n1_y;
    logic signed [15:0]     n1_z;
    logic [SIDE_W-1:0]      n1_side;

    dnrb_norm #(.W(VW), .SW(SIDE_W)) u_norm_detail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fb_valid_reg),
        .in_x      (fb_dx_reg),
        .in_y      (fb_dy_reg),
        .in_z      (fb_dz_reg),
        .in_side   (fb_side_reg),
        .out_valid (n1_valid),
        .out_x     (n1_x),
        .out_y     (n1_y),
        .out_z     (n1_z),
        .out_side  (n1_side)
    );

    // stage c: add to macro normal
    logic                   fc_valid_reg;
    logic signed [VW-1:0]   fc_bx_reg;
    logic signed [VW-1:0]   fc_by_reg;
    logic signed [VW-1:0]   fc_bz_reg;
    logic [RW-1:0]          fc_rough_reg;
    logic signed [15:0]     side_mx;
    logic signed [15:0]     side_my;
    logic signed [15:0]     side_mz;

    assign side_mx = n1_side[SIDE_W-1 -: 16];
    assign side_my = n1_side[SIDE_W-17 -: 16];
    assign side_mz = n1_side[SIDE_W-33 -: 16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fc_valid_reg <= n1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fc_bx_reg    <= VW'(side_mx) + VW'(n1_x);
            fc_by_reg    <= VW'(side_my) + VW'(n1_y);
            fc_bz_reg    <= VW'(side_mz);
            fc_rough_reg <= n1_side[RW-1:0];
        end
    end

    // blended normalise
    logic [RW-1:0] n2_rough;

    dnrb_norm #(.W(VW), .SW(RW)) u_norm_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fc_valid_reg),
        .in_x      (fc_bx_reg),
        .in_y      (fc_by_reg),
        .in_z      (fc_bz_reg),
        .in_side   (fc_rough_reg),
        .out_valid (n2_valid),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_side  (n2_rough)
    );

    assign out_valid = n2_valid;
    assign out_rough = n2_rough;

endmodule

`default_nettype wire

>>> rtl/dnrb_checker.sv
`default_nettype none

module dnrb_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  wire signed [15:0]   out_x,
    input  wire signed [15:0]   out_y,
    input  wire signed [15:0]   out_z,
    input  wire [14:0]          out_rough
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_rough))
        else $error("result dropped while stalled");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_x >= -16384 && out_x <= 16384 && out_y >= -16384
                      && out_y <= 16384 && out_z >= -16384 && out_z <= 16384)
        else $error("normal component out of range");

    a_rough_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rough <= 15'd16384)
        else $error("roughness out of range");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_x != 16'sd0) || (out_y != 16'sd0) || (out_z != 16'sd0))
        else $error("zero normal");

endmodule

bind detail_normal_roughness_blend dnrb_checker u_dnrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_rough (out_rough)
);

`default_nettype wire

>>> test/detail_normal_roughness_blend_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module detail_normal_roughness_blend_tb;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic [14:0]        mr;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [14:0]        dr;
    } pixel_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [14:0]        r;
    } blend_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] macro_x, macro_y, macro_z, detail_x, detail_y, detail_z;
    logic [14:0] macro_rough, detail_rough;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] out_x, out_y, out_z;
    logic [14:0] out_rough;
    logic cfg_wr_en;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    pixel_t pending_pixels[$];
    blend_t expected_blends[$];
    longint cur_intensity;
    longint cur_rough_blend;
    int     mismatch_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;
    longint cycle_count = 0;
    bit     holding;
    event   hold_off_go;

    detail_normal_roughness_blend DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .macro_x(macro_x), .macro_y(macro_y), .macro_z(macro_z),
        .macro_rough(macro_rough),
        .detail_x(detail_x), .detail_y(detail_y), .detail_z(detail_z),
        .detail_rough(detail_rough),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_rough(out_rough),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic void unit_vector(input longint vx, input longint vy,
                                        input longint vz, output longint ox,
                                        output longint oy, output longint oz);
        longint len2;
        longint len;
        longint c[3];
        longint v[3];
        len2 = vx * vx + vy * vy + vz * vz;
        if (len2 == 0)
        begin
            ox = 0;
            oy = 0;
            oz = dnrb_pkg::ONE;
        end
        else
        begin
            len = int_sqrt(len2 << dnrb_pkg::NORM_SHIFT);
            v[0] = vx;
            v[1] = vy;
            v[2] = vz;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = round_div(v[i] * dnrb_pkg::ONE * 4096, len);
                if (c[i] > dnrb_pkg::ONE)
                    c[i] = dnrb_pkg::ONE;
                if (c[i] < -dnrb_pkg::ONE)
                    c[i] = -dnrb_pkg::ONE;
            end
            ox = c[0];
            oy = c[1];
            oz = c[2];
        end
    endfunction

    function automatic blend_t blend_pixel(pixel_t p);
        blend_t res;
        longint sx, sy, nx, ny, nz, ox, oy, oz, r;
        sx = round_div(longint'(p.dx) * cur_intensity, dnrb_pkg::ONE);
        sy = round_div(longint'(p.dy) * cur_intensity, dnrb_pkg::ONE);
        unit_vector(sx, sy, longint'(p.dz), nx, ny, nz);
        unit_vector(longint'(p.mx) + nx, longint'(p.my) + ny, longint'(p.mz), ox, oy, oz);
        r = longint'(p.mr) + round_div((2 * longint'(p.dr) - dnrb_pkg::ONE)
                                       * cur_rough_blend, dnrb_pkg::ONE);
        if (r < 0)
            r = 0;
        if (r > dnrb_pkg::ONE)
            r = dnrb_pkg::ONE;
        res.x = ox[15:0];
        res.y = oy[15:0];
        res.z = oz[15:0];
        res.r = r[14:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {macro_x, macro_y, macro_z, macro_rough} <= '0;
            {detail_x, detail_y, detail_z, detail_rough} <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_t p;
                p = pending_pixels.pop_front();
                expected_blends.push_back(blend_pixel(p));
                in_valid <= 1'b1;
                macro_x <= p.mx;
                macro_y <= p.my;
                macro_z <= p.mz;
                macro_rough <= p.mr;
                detail_x <= p.dx;
                detail_y <= p.dy;
                detail_z <= p.dz;
                detail_rough <= p.dr;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always
    begin
        @(hold_off_go);
        holding <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        holding <= 1'b0;
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_blends.size() == 0)
                    report_mismatch("unexpected result", out_x, 0);
                else
                begin
                    blend_t e;
                    e = expected_blends.pop_front();
                    if (out_x !== e.x)
                        report_mismatch("out_x", out_x, e.x);
                    if (out_y !== e.y)
                        report_mismatch("out_y", out_y, e.y);
                    if (out_z !== e.z)
                        report_mismatch("out_z", out_z, e.z);
                    if (out_rough !== e.r)
                        report_mismatch("out_rough", out_rough, e.r);
                end
            end
            if (holding)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int k;
        k = $urandom_range(9);
        if (k == 0)
            p = pixel_t'(126'({$urandom, $urandom, $urandom, $urandom}));
        else
        begin
            p.mx = rand_comp();
            p.my = rand_comp();
            p.mz = rand_comp();
            p.dx = rand_comp();
            p.dy = rand_comp();
            p.dz = rand_comp();
            p.mr = 15'($urandom_range(dnrb_pkg::ONE));
            p.dr = 15'($urandom_range(dnrb_pkg::ONE));
            if (k == 1)
                p.mz = 0;
            if (k == 2)
                {p.dx, p.dy, p.dz} = '0;
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || expected_blends.size() > 0 || in_valid)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input dnrb_pkg::cfg_reg_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == dnrb_pkg::REG_INTENSITY)
            cur_intensity = val;
        else
            cur_rough_blend = val[14:0];
        @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(int mx, int my, int mz, int mr,
                                          int dx, int dy, int dz, int dr);
        pixel_t p;
        p.mx = 16'(mx); p.my = 16'(my); p.mz = 16'(mz); p.mr = 15'(mr);
        p.dx = 16'(dx); p.dy = 16'(dy); p.dz = 16'(dz); p.dr = 15'(dr);
        return p;
    endfunction

    initial
    begin
        int settings_i[6];
        int settings_b[6];
        int idle_s[4];
        int stall_s[4];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = dnrb_pkg::REG_INTENSITY;
        cfg_data = '0;
        cur_intensity = 16384;
        cur_rough_blend = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, with edge cases
        pending_pixels.push_back(make_pixel(0, 0, 16384, 0, 0, 0, 16384, 0));
        pending_pixels.push_back(make_pixel(0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_pixels.push_back(make_pixel(-16384, -16384, -16384, 0,
                                            -16384, -16384, -16384, 0));
        pending_pixels.push_back(make_pixel(16384, 16384, 16384, 16384,
                                            16384, 16384, 16384, 16384));
        pending_pixels.push_back(make_pixel(-32768, 32767, -32768, 32767,
                                            32767, -32768, 32767, 32767));
        pending_pixels.push_back(make_pixel(1, 0, 0, 8192, 0, 0, 1, 8192));
        pending_pixels.push_back(make_pixel(16384, 0, 0, 100, -16384, 0, 0, 0));
        pending_pixels.push_back(make_pixel(0, -1, 0, 0, 1, 1, 0, 16384));
        wait_drained();
        write_reg(dnrb_pkg::REG_ROUGH_BLEND, 16384);
        pending_pixels.push_back(make_pixel(0, 0, 16384, 0, 0, 0, 16384, 0));
        pending_pixels.push_back(make_pixel(0, 0, 16384, 16384, 0, 0, 16384, 16384));
        pending_pixels.push_back(make_pixel(0, 0, 16384, 32767, 0, 0, 16384, 32767));
        pending_pixels.push_back(make_pixel(0, 0, 16384, 0, 0, 0, 16384, 32767));
        wait_drained();
        write_reg(dnrb_pkg::REG_INTENSITY, 0);
        pending_pixels.push_back(make_pixel(5000, -3000, 0, 2000, 16384, 16384, 0, 9000));
        pending_pixels.push_back(make_pixel(0, 0, 0, 2000, 16384, -16384, 0, 9000));
        wait_drained();
        write_reg(dnrb_pkg::REG_INTENSITY, 16'hFFFF);
        write_reg(dnrb_pkg::REG_ROUGH_BLEND, 16'h7FFF);
        pending_pixels.push_back(make_pixel(100, 100, 16384, 8000, 16384, -16384, 1, 0));
        pending_pixels.push_back(make_pixel(-100, 3, 200, 16384, -16384, 16384, 0, 16384));
        wait_drained();

        settings_i = '{16384, 0, 65535, 8192, 32768, 16384};
        settings_b = '{0, 16384, 8192, 0, 16384, 12000};
        idle_s = '{0, 69, 0, 22};
        stall_s = '{0, 0, 69, 22};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(dnrb_pkg::REG_INTENSITY, 16'(settings_i[ph]));
            write_reg(dnrb_pkg::REG_ROUGH_BLEND, 16'(settings_b[ph]));
            send_idle_pct = idle_s[ph % 4];
            recv_stall_pct = stall_s[ph % 4];
            if (ph == 4)
            begin
                hold_off_cycles = 400;
                -> hold_off_go;
            end
            for (int n = 0; n < 155; n++)
                pending_pixels.push_back(rand_pixel());
            wait_drained();
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
